>>> hdl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types, codes and lookup for the base64url decoder
// Holds the result beat layout, status codes and the alphabet decode table.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_PAD  = 2'd1,
    STATUS_BAD_CHAR = 2'd2
  } status_t;

  // Output queue geometry
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic       item_kind;
    logic [7:0] data_byte;
    status_t    status;
    logic       end_of_run;
  } res_t;

  // Up to two results per character; res0 goes out first
  typedef struct packed {
    logic [1:0] n;
    res_t       res0;
    res_t       res1;
  } step_out_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sym_t;

  // Alphabet decode: A-Z, a-z, 0-9, '-', '_'
  function automatic sym_t sym_lookup(input logic [7:0] c);
    sym_t r;
    r.valid = 1'b1;
    r.value = '0;
    priority if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2D) begin
      r.value = 6'd62;
    end else if (c == 8'h5F) begin
      r.value = 6'd63;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> hdl/b64d_in_if.sv
// ----------------------------------------------------------------------------
// b64d_in_if: text character channel
// Valid/ready channel carrying one encoded character and its last mark.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       final_char;

  modport source (output valid, output text_char, output final_char, input ready);
  modport sink   (input valid, input text_char, input final_char, output ready);
endinterface

>>> hdl/b64d_out_if.sv
// ----------------------------------------------------------------------------
// b64d_out_if: decoded result channel
// Valid/ready channel carrying data bytes and end-of-message status beats.
// ----------------------------------------------------------------------------
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       end_of_run;

  modport source (output valid, output item_kind, output data_byte, output status,
                  output end_of_run, input ready);
  modport sink   (input valid, input item_kind, input data_byte, input status,
                  input end_of_run, output ready);
endinterface

>>> hdl/b64d_step.sv
// ----------------------------------------------------------------------------
// b64d_step: per-character decode and message state
// Updates the bit store and padding state, forms the results of one character.
// ----------------------------------------------------------------------------
module b64d_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic [7:0]          text_char,
  input  logic                final_char,
  output b64d_pkg::step_out_t step_out
);

  logic [5:0] residual_bits,  residual_bits_next;
  logic [2:0] residual_count, residual_count_next;
  logic [1:0] symbol_phase,   symbol_phase_next;
  logic [1:0] pad_count,      pad_count_next;
  logic       pad_misplaced,  pad_misplaced_next;
  logic       bad_char_seen,  bad_char_seen_next;

  b64d_pkg::sym_t    sym;
  b64d_pkg::status_t status;
  b64d_pkg::res_t    data_res;
  b64d_pkg::res_t    status_res;
  logic [11:0]       bit_store;
  logic [3:0]        total;
  logic [3:0]        drain;
  logic [11:0]       keep_mask;
  logic              emit;

  always_comb begin
    sym                 = b64d_pkg::sym_lookup(text_char);
    bit_store           = {residual_bits, sym.value};
    total               = 4'(residual_count) + 4'd6;
    drain               = total - 4'd8;
    keep_mask           = (12'd1 << drain) - 12'd1;
    emit                = 1'b0;
    residual_bits_next  = residual_bits;
    residual_count_next = residual_count;
    symbol_phase_next   = symbol_phase;
    pad_count_next      = pad_count;
    pad_misplaced_next  = pad_misplaced;
    bad_char_seen_next  = bad_char_seen;

    if (text_char == b64d_pkg::PAD_CHAR) begin
      if (pad_count != 2'd3) begin
        pad_count_next = pad_count + 2'd1;
      end
    end else begin
      if (pad_count != 2'd0) begin
        pad_misplaced_next = 1'b1;
        pad_count_next     = 2'd0;
      end
      symbol_phase_next = symbol_phase + 2'd1;
      if (sym.valid) begin
        if (total >= 4'd8) begin
          emit                = 1'b1;
          residual_bits_next  = 6'(bit_store & keep_mask);
          residual_count_next = 3'(drain);
        end else begin
          residual_bits_next  = bit_store[5:0];
          residual_count_next = 3'(total);
        end
      end else begin
        bad_char_seen_next = 1'b1;
      end
    end

    // Status uses the state left after this character
    priority if (pad_count_next == 2'd3 || pad_misplaced_next || symbol_phase_next == 2'd1) begin
      status = b64d_pkg::STATUS_BAD_PAD;
    end else if (bad_char_seen_next) begin
      status = b64d_pkg::STATUS_BAD_CHAR;
    end else begin
      status = b64d_pkg::STATUS_OK;
    end

    data_res.item_kind  = b64d_pkg::KIND_DATA;
    data_res.data_byte  = 8'(bit_store >> drain);
    data_res.status     = b64d_pkg::STATUS_OK;
    data_res.end_of_run = ~final_char;

    status_res.item_kind  = b64d_pkg::KIND_STATUS;
    status_res.data_byte  = 8'd0;
    status_res.status     = status;
    status_res.end_of_run = 1'b1;

    step_out.n    = item_valid ? (2'(emit) + 2'(final_char)) : 2'd0;
    step_out.res0 = emit ? data_res : status_res;
    step_out.res1 = status_res;

    // Message end: clear everything
    if (final_char) begin
      residual_bits_next  = '0;
      residual_count_next = '0;
      symbol_phase_next   = '0;
      pad_count_next      = '0;
      pad_misplaced_next  = 1'b0;
      bad_char_seen_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      residual_bits  <= '0;
      residual_count <= '0;
      symbol_phase   <= '0;
      pad_count      <= '0;
      pad_misplaced  <= 1'b0;
      bad_char_seen  <= 1'b0;
    end else if (item_valid) begin
      residual_bits  <= residual_bits_next;
      residual_count <= residual_count_next;
      symbol_phase   <= symbol_phase_next;
      pad_count      <= pad_count_next;
      pad_misplaced  <= pad_misplaced_next;
      bad_char_seen  <= bad_char_seen_next;
    end
  end

endmodule

>>> hdl/b64d_out_fifo.sv
// ----------------------------------------------------------------------------
// b64d_out_fifo: result queue
// Small queue taking up to two result beats per cycle, popping one.
// ----------------------------------------------------------------------------
module b64d_out_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [1:0]                         wr_n,
  input  b64d_pkg::res_t                     wr0,
  input  b64d_pkg::res_t                     wr1,
  input  logic                               pop,
  output b64d_pkg::res_t                     head,
  output logic [b64d_pkg::FIFO_CW-1:0]       count
);

  b64d_pkg::res_t                slots [b64d_pkg::FIFO_DEPTH];
  logic [b64d_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [b64d_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [b64d_pkg::FIFO_AW-1:0]  wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr + b64d_pkg::FIFO_AW'(1);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      slots[wr_ptr] <= wr0;
    end
    if (wr_n == 2'd2) begin
      slots[wr_ptr_plus1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + b64d_pkg::FIFO_AW'(wr_n);
      if (pop) begin
        rd_ptr <= rd_ptr + b64d_pkg::FIFO_AW'(1);
      end
      count <= count + b64d_pkg::FIFO_CW'(wr_n) - b64d_pkg::FIFO_CW'(pop);
    end
  end

endmodule

>>> hdl/base64url_decoder_core.sv
// ----------------------------------------------------------------------------
// base64url_decoder_core: streaming base64url decoder
// One character per input beat; emits data byte beats and a status beat.
// ----------------------------------------------------------------------------
// Usage:
//   text_in carries one encoded character per beat (text_char) with
//   final_char marking the last character of a message. result_out carries
//   data byte beats (item_kind 0) and, after the last character, one status
//   beat (item_kind 1: 0 ok, 1 bad padding, 2 invalid character).
//   end_of_run marks the last beat that a character causes.
// Timing:
//   A character taken from text_in sits in the input register, is decoded,
//   and its results are written into the result queue, whose head drives
//   result_out. One character is taken every cycle while text_in.ready is
//   high; a character that yields two beats needs two beats on result_out,
//   so the output port sets the long-run rate.
// Stall and reset:
//   The 8-entry result queue keeps room for the item in flight plus the next
//   one; text_in.ready drops when a stalled receiver fills it. Reset clears
//   the decode state, the input register and the queue.
// ----------------------------------------------------------------------------
module base64url_decoder_core (
  input  logic              clk,
  input  logic              rst,
  b64d_in_if.sink           text_in,
  b64d_out_if.source        result_out
);

  // Input register
  logic       item_valid;
  logic [7:0] text_char;
  logic       final_char;

  b64d_pkg::step_out_t                 step_out;
  b64d_pkg::res_t                      head;
  logic [b64d_pkg::FIFO_CW-1:0]        count;
  logic [b64d_pkg::FIFO_CW+1:0]        reserved;
  logic                                accept;
  logic                                pop;

  // Reserve two slots for the registered item and two for the new one
  assign reserved = (b64d_pkg::FIFO_CW+2)'(count)
                  + (item_valid ? (b64d_pkg::FIFO_CW+2)'(2) : '0)
                  + (b64d_pkg::FIFO_CW+2)'(2);
  assign text_in.ready = (reserved <= (b64d_pkg::FIFO_CW+2)'(b64d_pkg::FIFO_DEPTH));
  assign accept        = text_in.valid & text_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
    end
  end

  // Payload: load on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      text_char  <= text_in.text_char;
      final_char <= text_in.final_char;
    end
  end

  b64d_step u_step (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .text_char  (text_char),
    .final_char (final_char),
    .step_out   (step_out)
  );

  b64d_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr_n  (step_out.n),
    .wr0   (step_out.res0),
    .wr1   (step_out.res1),
    .pop   (pop),
    .head  (head),
    .count (count)
  );

  // Drive the result channel from the queue head
  assign result_out.valid      = (count != '0);
  assign pop                   = result_out.valid & result_out.ready;
  assign result_out.item_kind  = head.item_kind;
  assign result_out.data_byte  = head.data_byte;
  assign result_out.status     = head.status;
  assign result_out.end_of_run = head.end_of_run;

endmodule
